[hdl/skf_pkg.sv]
package skf_pkg;

  // Fixed widths of the register file and the error state.
  localparam int unsigned REG_W    = 24;
  localparam int unsigned NOISE_W  = 16;
  localparam int unsigned ERR_W    = 32;
  localparam int unsigned Q_BITS   = 16;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_MEAS_ERR  = 2'd0;
  localparam logic [1:0] REG_INIT_ERR  = 2'd1;
  localparam logic [1:0] REG_NOISE     = 2'd2;

  // Which product the shared multiplier works on.
  typedef enum logic [1:0] {
    PROD_GAIN  = 2'd0,
    PROD_ERR   = 2'd1,
    PROD_NOISE = 2'd2
  } prod_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load;
    logic  div_step;
    logic  mul_lo;
    logic  mul_hi;
    logic  acc;
    logic  update;
    prod_e prod;
  } cmd_t;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [REG_W-1:0]   meas_err;
    logic [NOISE_W-1:0] noise;
    logic               init_load;
    logic [REG_W-1:0]   init_wdata;
  } cfg_t;

endpackage

[hdl/skf_regs.sv]
module skf_regs #(
  parameter logic [23:0] RESET_ERR = 24'd131072
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [skf_pkg::ADDR_W-1:0]   paddr,
  input  logic [skf_pkg::DATA_W-1:0]   pwdata,
  output logic [skf_pkg::DATA_W-1:0]   prdata,
  output skf_pkg::cfg_t                cfg_o
);

  localparam logic [skf_pkg::NOISE_W-1:0] NOISE_RESET = 16'd655;

  logic [skf_pkg::REG_W-1:0]   meas_q, meas_d;
  logic [skf_pkg::REG_W-1:0]   init_q, init_d;
  logic [skf_pkg::NOISE_W-1:0] noise_q, noise_d;
  logic                        wr_en;
  logic [1:0]                  idx;

  assign idx   = paddr[3:2];
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    meas_d  = meas_q;
    init_d  = init_q;
    noise_d = noise_q;
    if (wr_en) begin
      unique case (idx)
        skf_pkg::REG_MEAS_ERR: meas_d  = pwdata[skf_pkg::REG_W-1:0];
        skf_pkg::REG_INIT_ERR: init_d  = pwdata[skf_pkg::REG_W-1:0];
        skf_pkg::REG_NOISE:    noise_d = pwdata[skf_pkg::NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_q  <= RESET_ERR;
      init_q  <= RESET_ERR;
      noise_q <= NOISE_RESET;
    end else begin
      meas_q  <= meas_d;
      init_q  <= init_d;
      noise_q <= noise_d;
    end
  end

  always_comb begin
    unique case (idx)
      skf_pkg::REG_MEAS_ERR: prdata = skf_pkg::DATA_W'(meas_q);
      skf_pkg::REG_INIT_ERR: prdata = skf_pkg::DATA_W'(init_q);
      skf_pkg::REG_NOISE:    prdata = skf_pkg::DATA_W'(noise_q);
      default:               prdata = '0;
    endcase
  end

  // Writing the initial error also reloads the error state in the datapath.
  assign cfg_o.meas_err   = meas_q;
  assign cfg_o.noise      = noise_q;
  assign cfg_o.init_load  = wr_en && (idx == skf_pkg::REG_INIT_ERR);
  assign cfg_o.init_wdata = pwdata[skf_pkg::REG_W-1:0];

endmodule

[hdl/skf_ctrl.sv]
module skf_ctrl #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output skf_pkg::cmd_t cmd_o
);

  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_MLO  = 6'b000100,
    ST_MHI  = 6'b001000,
    ST_ACC  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  skf_pkg::prod_e      prod_q, prod_d;
  logic                out_valid_q, out_valid_d;
  logic                slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DIV;
          cnt_d   = CNT_W'(FRAC_BITS);
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_MLO;
          prod_d  = skf_pkg::PROD_GAIN;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_MLO: state_d = ST_MHI;
      ST_MHI: state_d = ST_ACC;
      ST_ACC: begin
        unique case (prod_q)
          skf_pkg::PROD_GAIN: begin
            prod_d  = skf_pkg::PROD_ERR;
            state_d = ST_MLO;
          end
          skf_pkg::PROD_ERR: begin
            prod_d  = skf_pkg::PROD_NOISE;
            state_d = ST_MLO;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.mul_lo   = (state_q == ST_MLO);
    cmd_o.mul_hi   = (state_q == ST_MHI);
    cmd_o.acc      = (state_q == ST_ACC);
    cmd_o.update   = (state_q == ST_DONE) && slot_free;
    cmd_o.prod     = prod_q;
  end

  assign out_valid_d = cmd_o.update || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      prod_q      <= skf_pkg::PROD_GAIN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      prod_q      <= prod_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[hdl/skf_dp.sv]
module skf_dp #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned FRAC_BITS   = 16,
  parameter logic [23:0] RESET_ERR   = 24'd131072
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  skf_pkg::cmd_t                     cmd_i,
  input  skf_pkg::cfg_t                     cfg_i,
  input  logic [SAMPLE_BITS-1:0]            sample_i,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0]  estimate_o
);

  localparam int unsigned EST_W = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned K_W   = FRAC_BITS + 1;
  localparam int unsigned HALF  = (EST_W + 1) / 2;
  localparam int unsigned B_W   = 2 * HALF;
  localparam int unsigned ERR_W = skf_pkg::ERR_W;
  localparam int unsigned P_W   = ERR_W + HALF;
  localparam int unsigned ACC_W = ERR_W + B_W;
  localparam int unsigned SUM_W = ERR_W + 1;
  localparam int unsigned R_W   = ERR_W + 2;
  localparam int unsigned ES_W  = ((EST_W > ERR_W) ? EST_W : ERR_W) + 1;
  localparam logic [K_W-1:0] ONE_K = {1'b1, {FRAC_BITS{1'b0}}};

  logic [EST_W-1:0] last_q;
  logic [ERR_W-1:0] err_q;
  logic             up_q;
  logic [EST_W-1:0] mag_q;
  logic [SUM_W-1:0] sum_q;
  logic             zero_q;
  logic [R_W-1:0]   rem_q;
  logic [K_W-1:0]   quot_q;
  logic [P_W-1:0]   p_q, lo_q;
  logic [EST_W-1:0] delta_q;
  logic [ERR_W-1:0] err1_q;
  logic [EST_W-1:0] err2_q;

  logic [EST_W-1:0] s_ext;
  logic             s_ge;
  logic [SUM_W-1:0] sum_now;
  logic             rem_ge;
  logic [R_W-1:0]   rem_sub;
  logic [K_W-1:0]   gain;
  logic [K_W-1:0]   one_minus_k;
  logic [ERR_W-1:0] opa;
  logic [B_W-1:0]   opb;
  logic [HALF-1:0]  bsel;
  logic [P_W-1:0]   mult;
  logic [ACC_W-1:0] full;
  logic [ES_W-1:0]  err_sum;
  logic [ERR_W-1:0] err_sat;
  logic [EST_W-1:0] next_est;

  assign s_ext   = {sample_i, {FRAC_BITS{1'b0}}};
  assign s_ge    = (s_ext >= last_q);
  assign sum_now = SUM_W'(err_q) + SUM_W'(cfg_i.meas_err);

  // One quotient bit per step, most significant first; the first step
  // yields the integer bit of the gain.
  assign rem_ge  = (rem_q >= R_W'(sum_q));
  assign rem_sub = rem_ge ? (rem_q - R_W'(sum_q)) : rem_q;

  assign gain        = zero_q ? '0 : quot_q;
  assign one_minus_k = ONE_K - gain;

  always_comb begin
    unique case (cmd_i.prod)
      skf_pkg::PROD_GAIN: begin
        opa = ERR_W'(gain);
        opb = B_W'(mag_q);
      end
      skf_pkg::PROD_ERR: begin
        opa = err_q;
        opb = B_W'(one_minus_k);
      end
      skf_pkg::PROD_NOISE: begin
        opa = ERR_W'(cfg_i.noise);
        opb = B_W'(delta_q);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign bsel = cmd_i.mul_hi ? opb[B_W-1:HALF] : opb[HALF-1:0];
  assign mult = P_W'(opa) * P_W'(bsel);
  assign full = ACC_W'(lo_q) + (ACC_W'(p_q) << HALF);

  assign err_sum  = ES_W'(err1_q) + ES_W'(err2_q);
  assign err_sat  = (|err_sum[ES_W-1:ERR_W]) ? '1 : err_sum[ERR_W-1:0];
  assign next_est = up_q ? (last_q + delta_q) : (last_q - delta_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      up_q   <= s_ge;
      mag_q  <= s_ge ? (s_ext - last_q) : (last_q - s_ext);
      sum_q  <= sum_now;
      zero_q <= (sum_now == '0);
      rem_q  <= R_W'(err_q);
      quot_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= {rem_sub[R_W-2:0], 1'b0};
      quot_q <= {quot_q[K_W-2:0], rem_ge};
    end
    if (cmd_i.mul_lo || cmd_i.mul_hi) begin
      p_q <= mult;
    end
    if (cmd_i.mul_hi) begin
      lo_q <= p_q;
    end
    if (cmd_i.acc) begin
      unique case (cmd_i.prod)
        skf_pkg::PROD_GAIN:  delta_q <= full[FRAC_BITS +: EST_W];
        skf_pkg::PROD_ERR:   err1_q  <= full[FRAC_BITS +: ERR_W];
        skf_pkg::PROD_NOISE: err2_q  <= full[skf_pkg::Q_BITS +: EST_W];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      err_q  <= ERR_W'(RESET_ERR);
    end else begin
      priority if (cfg_i.init_load) begin
        err_q <= ERR_W'(cfg_i.init_wdata);
      end else if (cmd_i.update) begin
        last_q <= next_est;
        err_q  <= err_sat;
      end else begin
        last_q <= last_q;
        err_q  <= err_q;
      end
    end
  end

  // The stored estimate only changes once the previous result was taken.
  assign estimate_o = last_q;

endmodule

[hdl/scalar_kalman_filter_core.sv]
// Scalar Kalman filter over ADC samples.
// Input channel: sample_i with in_valid_i / in_stall_o. A request is taken at a
// rising edge with in_valid_i high and in_stall_o low. Each request yields one
// filtered estimate (unsigned fixed point, FRAC_BITS fraction bits) on
// estimate_o with out_valid_o / out_stall_i.
// Each request runs, from acceptance to the next acceptance, through the gain
// divider, which makes one quotient bit per cycle, then three products on one
// shared multiplier, each split into two halves and summed (low half, high
// half, accumulate), and one update step, in which the estimate and
// out_valid_o are registered.
// The next request is accepted while a result still waits in the output
// register; if the receiver stalls, the block finishes the new request and
// holds in its update step until the waiting result is taken.
// Registers (APB, 32-bit data): 0x0 measurement error, 0x4 initial error,
// whose write also reloads the error state, 0x8 process noise. Writes must be
// made only while the block is idle; the block itself does not enforce this.
// Reset clears the estimate to zero, sets both error registers and the error
// state to 2.0 and the process noise to about 0.01.
module scalar_kalman_filter_core #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [SAMPLE_BITS-1:0]            sample_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0]  estimate_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [skf_pkg::ADDR_W-1:0]        paddr,
  input  logic [skf_pkg::DATA_W-1:0]        pwdata,
  output logic [skf_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  // The value 2.0 in the register format; it wraps to zero when the
  // fraction is too wide for the 24-bit registers.
  localparam logic [skf_pkg::REG_W-1:0] RESET_ERR =
    skf_pkg::REG_W'(32'd2 << FRAC_BITS);

  skf_pkg::cmd_t cmd;
  skf_pkg::cfg_t cfg;

  // The register file never waits.
  assign pready = 1'b1;

  skf_regs #(
    .RESET_ERR(RESET_ERR)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .cfg_o  (cfg)
  );

  // The controller sequences the divider and the multiplier passes and owns
  // both handshakes.
  skf_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .cmd_o      (cmd)
  );

  // The datapath holds the filter state and all arithmetic.
  skf_dp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .RESET_ERR  (RESET_ERR)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .cfg_i     (cfg),
    .sample_i  (sample_i),
    .estimate_o(estimate_o)
  );

`ifndef SYNTH
  // After a request is taken the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted twice in a row");

  // The state is never updated over a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.update |-> (!out_valid_o || !out_stall_i))
    else $error("pending result overwritten");

  // A new result appears only through an update step.
  a_valid_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.update))
    else $error("result valid without update");
`endif

endmodule
